/* design/wve_pkg.sv */
// Shared types and constants for the windowed velocity estimator.
// No dependencies; the interface, root, CORDIC and top-level files refer to this package by scoped names.
`default_nettype none

package wve_pkg;

  localparam int POS_W        = 16;
  localparam int TIME_W       = 48;
  localparam int VEL_W        = 32;
  localparam int HEAD_W       = 16;
  localparam int MAG_W        = 36;   // |dpos| * 1e6 always fits here
  localparam int SQ_W         = 64;
  localparam int ROOT_W       = 32;
  localparam int ANG_W        = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 35;

  localparam logic [19:0]       USEC_PER_SEC = 20'd1000000;
  localparam logic [VEL_W-2:0]  VEL_LIMIT    = 31'h7FFF_FFFF;
  localparam logic [ANG_W-1:0]  HALF_TURN    = 32'h8000_0000;
  localparam logic [ANG_W-1:0]  ROUND_HALF   = 32'h0000_8000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_VGO,
    S_VWAIT,
    S_VEL,
    S_SUM,
    S_MGO,
    S_MWAIT,
    S_MEAN,
    S_SQ,
    S_FGO,
    S_FWAIT,
    S_OUT
  } state_e;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* design/wve_stream_if.sv */
// Valid/ready channel interfaces for position samples and velocity results.
// Depends on wve_pkg for field widths.
`default_nettype none

interface wve_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [wve_pkg::POS_W-1:0]  pos_x;
  logic signed [wve_pkg::POS_W-1:0]  pos_y;
  logic        [wve_pkg::TIME_W-1:0] time_us;

  modport source (output valid, pos_x, pos_y, time_us, input ready);
  modport sink   (input valid, pos_x, pos_y, time_us, output ready);
endinterface

interface wve_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [wve_pkg::VEL_W-1:0]  vel_x;
  logic signed [wve_pkg::VEL_W-1:0]  vel_y;
  logic        [wve_pkg::ROOT_W-1:0] speed;
  logic        [wve_pkg::HEAD_W-1:0] heading;

  modport source (output valid, vel_x, vel_y, speed, heading, input ready);
  modport sink   (input valid, vel_x, vel_y, speed, heading, output ready);
endinterface

`default_nettype wire

/* design/wve_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module wve_ram #(
  parameter int W  = 8,
  parameter int D  = 8,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/wve_div.sv */
// Restoring unsigned divider, one quotient bit per cycle; one lane per axis.
// No dependencies.
`default_nettype none

module wve_div #(
  parameter int NW = 36,
  parameter int DW = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output      logic          busy_o,
  output      logic [NW-1:0] quotient_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   shifted;
  logic          take;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign take    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CW'(1);
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? DW'(shifted - {1'b0, dvs_q}) : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* design/wve_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on wve_pkg for widths.
`default_nettype none

module wve_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wve_pkg::SQ_W-1:0]    radicand_i,
  output      logic                        busy_o,
  output      logic [wve_pkg::ROOT_W-1:0]  root_o
);

  localparam int RW = wve_pkg::ROOT_W + 4;

  logic [5:0]                    cnt_q;
  logic                          busy_q;
  logic [wve_pkg::SQ_W-1:0]      rad_q;
  logic [RW-1:0]                 rem_q;
  logic [wve_pkg::ROOT_W-1:0]    root_q;
  logic [RW-1:0]                 shifted;
  logic [RW-1:0]                 trial;
  logic                          take;

  assign shifted = {rem_q[RW-3:0], rad_q[wve_pkg::SQ_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign take    = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(wve_pkg::ROOT_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[wve_pkg::SQ_W-3:0], 2'b00};
      rem_q  <= take ? shifted - trial : shifted;
      root_q <= {root_q[wve_pkg::ROOT_W-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* design/wve_cordic.sv */
// Iterative CORDIC in vectoring mode giving the heading as a fraction of a turn.
// Depends on wve_pkg for widths and the arctangent table.
`default_nettype none

module wve_cordic (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [wve_pkg::VEL_W-1:0]   x_i,
  input  wire logic signed [wve_pkg::VEL_W-1:0]   y_i,
  output      logic                               busy_o,
  output      logic [wve_pkg::HEAD_W-1:0]         heading_o
);

  localparam int CW = wve_pkg::CORDIC_W;

  logic                         busy_q;
  logic [4:0]                   step_q;
  logic                         zero_q;
  logic signed [CW-1:0]         x_q;
  logic signed [CW-1:0]         y_q;
  logic [wve_pkg::ANG_W-1:0]    z_q;
  logic signed [CW-1:0]         x_ext;
  logic signed [CW-1:0]         y_ext;
  logic signed [CW-1:0]         xs;
  logic signed [CW-1:0]         ys;
  logic [wve_pkg::ANG_W-1:0]    z_rnd;

  assign x_ext = CW'(x_i);
  assign y_ext = CW'(y_i);
  assign xs    = x_q >>> step_q;
  assign ys    = y_q >>> step_q;
  assign z_rnd = z_q + wve_pkg::ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      busy_q <= step_q != 5'(wve_pkg::CORDIC_STEPS - 1);
    end
  end

  // A vector in the left half plane is turned by a half turn first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q <= -x_ext;
        y_q <= -y_ext;
        z_q <= wve_pkg::HALF_TURN;
      end else begin
        x_q <= x_ext;
        y_q <= y_ext;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + wve_pkg::atan_turn(step_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - wve_pkg::atan_turn(step_q);
      end
    end
  end

  assign busy_o    = busy_q;
  assign heading_o = zero_q ? '0 : z_rnd[wve_pkg::ANG_W-1 -: wve_pkg::HEAD_W];

endmodule

`default_nettype wire

/* design/windowed_velocity_estimator.sv */
// Top level of the windowed velocity estimator: sample ring, per-axis divider
// lanes, averaging, and the root and CORDIC lanes. Depends on wve_pkg,
// wve_stream_if, wve_ram, wve_div, wve_sqrt and wve_cordic.
//
//   channel    dir  handshake     payload
//   sample_i   in   valid/ready   pos_x, pos_y, time_us
//   result_o   out  valid/ready   vel_x, vel_y, speed, heading
//
// One item at a time; a new item is taken only once the last one's result has been loaded into
// the output register. Each item runs load, velocity divide, history sum, reciprocal mean
// multiply and squaring, then the square root with CORDIC beside it, and is then presented.
// Reset clears the slot pointers, sums and valid bits, so every ring entry reads as zero.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module windowed_velocity_estimator #(
  parameter int WINDOW_DEPTH = 8,
  parameter int AVG_DEPTH    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  wve_sample_if.sink         sample_i,
  wve_result_if.source       result_o
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int HAW   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W = wve_pkg::VEL_W + HAW + 1;
  localparam int PW    = 2 * wve_pkg::POS_W + wve_pkg::TIME_W;
  localparam int HW    = 2 * wve_pkg::VEL_W;

  // The mean is |sum| * RECIP >> RK, exact for every |sum| below 2^SUM_W.
  localparam int RK    = SUM_W + HAW;
  localparam int RB    = RK + 1;
  localparam int CHK   = 8;
  localparam int NCH   = (RB + CHK - 1) / CHK;
  localparam int RPW   = NCH * CHK;
  localparam int ACC_W = SUM_W + RPW;
  localparam int MCW   = $clog2(NCH + 1);
  localparam logic [RPW-1:0] RECIP =
    RPW'(((64'd1 << RK) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  wve_pkg::state_e state_q, state_d;

  logic accept;
  logic out_free;
  logic vdiv_go, mdiv_go, fin_go;

  // Sample ring
  logic [AW-1:0]          wslot_q;
  logic [AW-1:0]          rslot;
  logic [WINDOW_DEPTH-1:0] pos_vld_q;
  logic                   pos_rvld_q;
  logic [PW-1:0]          pos_rdata;
  logic signed [15:0]     px_q, py_q;
  logic [wve_pkg::TIME_W-1:0] t_q;
  logic signed [15:0]     old_x, old_y;
  logic [wve_pkg::TIME_W-1:0] old_t;

  // Averaging history
  logic [HAW-1:0]         hslot_q, hcur_q;
  logic [AVG_DEPTH-1:0]   hist_vld_q;
  logic                   hist_rvld_q;
  logic [HW-1:0]          hist_rdata;
  logic signed [wve_pkg::VEL_W-1:0] old_vx, old_vy;
  logic signed [SUM_W-1:0] sumx_q, sumy_q;

  // Velocity lanes
  logic signed [16:0]     dpx, dpy;
  logic [16:0]            apx, apy;
  logic signed [wve_pkg::TIME_W:0] dt;
  logic [wve_pkg::MAG_W-1:0] magx_q, magy_q;
  logic                   negx_q, negy_q, dtpos_q;
  logic [wve_pkg::TIME_W-1:0] dt_q;
  logic                   vdivx_busy, vdivy_busy;
  logic [wve_pkg::MAG_W-1:0] qx, qy;
  logic signed [wve_pkg::VEL_W-1:0] vx_q, vy_q;

  // Mean lanes
  logic [MCW-1:0]         mcnt_q;
  logic [RPW-1:0]         rcp_q;
  logic [SUM_W-1:0]       absx, absy;
  logic [SUM_W-1:0]       mabsx_q, mabsy_q;
  logic [SUM_W+CHK-1:0]   ppx, ppy;
  logic [ACC_W-1:0]       accx_q, accy_q;
  logic [wve_pkg::VEL_W-1:0] mqx, mqy;
  logic signed [wve_pkg::VEL_W-1:0] mx_q, my_q;
  logic [wve_pkg::SQ_W-1:0] sqx_q, sqy_q;
  logic signed [wve_pkg::SQ_W-1:0] prodx, prody;

  logic                   sqrt_busy, cordic_busy;
  logic [wve_pkg::ROOT_W-1:0] root;
  logic [wve_pkg::HEAD_W-1:0] heading;

  logic                   out_valid_q;

  function automatic logic signed [wve_pkg::VEL_W-1:0] sat_vel(
    input logic [wve_pkg::MAG_W-1:0] q,
    input logic                      neg
  );
    logic [wve_pkg::VEL_W-2:0]       m;
    logic signed [wve_pkg::VEL_W-1:0] v;
    m = (q[wve_pkg::MAG_W-1:wve_pkg::VEL_W-1] != '0) ? wve_pkg::VEL_LIMIT
                                                      : q[wve_pkg::VEL_W-2:0];
    v = {1'b0, m};
    return neg ? -v : v;
  endfunction

  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign rslot    = (wslot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wve_pkg::S_IDLE:  if (accept) state_d = wve_pkg::S_LOAD;
      wve_pkg::S_LOAD:  state_d = wve_pkg::S_VGO;
      wve_pkg::S_VGO:   state_d = wve_pkg::S_VWAIT;
      wve_pkg::S_VWAIT: if (!vdivx_busy && !vdivy_busy) state_d = wve_pkg::S_VEL;
      wve_pkg::S_VEL:   state_d = wve_pkg::S_SUM;
      wve_pkg::S_SUM:   state_d = wve_pkg::S_MGO;
      wve_pkg::S_MGO:   state_d = wve_pkg::S_MWAIT;
      wve_pkg::S_MWAIT: if (mcnt_q == '0) state_d = wve_pkg::S_MEAN;
      wve_pkg::S_MEAN:  state_d = wve_pkg::S_SQ;
      wve_pkg::S_SQ:    state_d = wve_pkg::S_FGO;
      wve_pkg::S_FGO:   state_d = wve_pkg::S_FWAIT;
      wve_pkg::S_FWAIT: if (!sqrt_busy && !cordic_busy) state_d = wve_pkg::S_OUT;
      wve_pkg::S_OUT:   if (out_free) state_d = wve_pkg::S_IDLE;
      default:          state_d = wve_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    sample_i.ready = 1'b0;
    vdiv_go        = 1'b0;
    mdiv_go        = 1'b0;
    fin_go         = 1'b0;
    case (state_q)
      wve_pkg::S_IDLE: sample_i.ready = 1'b1;
      wve_pkg::S_VGO:  vdiv_go = 1'b1;
      wve_pkg::S_MGO:  mdiv_go = 1'b1;
      wve_pkg::S_FGO:  fin_go  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wve_pkg::S_IDLE;
      wslot_q     <= '0;
      hslot_q     <= '0;
      hcur_q      <= '0;
      pos_vld_q   <= '0;
      pos_rvld_q  <= 1'b0;
      hist_vld_q  <= '0;
      hist_rvld_q <= 1'b0;
      sumx_q      <= '0;
      sumy_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        wslot_q            <= rslot;
        pos_vld_q[wslot_q] <= 1'b1;
        pos_rvld_q         <= pos_vld_q[rslot];
        hist_rvld_q        <= hist_vld_q[hslot_q];
        hcur_q             <= hslot_q;
        hslot_q            <= (hslot_q == HAW'(AVG_DEPTH - 1)) ? '0 : hslot_q + 1'b1;
      end
      if (state_q == wve_pkg::S_SUM) begin
        hist_vld_q[hcur_q] <= 1'b1;
        sumx_q <= sumx_q + SUM_W'(vx_q) - SUM_W'(old_vx);
        sumy_q <= sumy_q + SUM_W'(vy_q) - SUM_W'(old_vy);
      end
      if (mdiv_go) begin
        mcnt_q <= MCW'(NCH);
      end else if (mcnt_q != '0) begin
        mcnt_q <= mcnt_q - 1'b1;
      end
      if (state_q == wve_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  wve_ram #(.W(PW), .D(WINDOW_DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wslot_q),
    .wdata_i ({sample_i.pos_y, sample_i.pos_x, sample_i.time_us}),
    .re_i    (accept),
    .raddr_i (rslot),
    .rdata_o (pos_rdata)
  );

  wve_ram #(.W(HW), .D(AVG_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == wve_pkg::S_SUM),
    .waddr_i (hcur_q),
    .wdata_i ({vy_q, vx_q}),
    .re_i    (accept),
    .raddr_i (hslot_q),
    .rdata_o (hist_rdata)
  );

  // Entries never written read as the reset value of zero.
  assign old_t  = pos_rvld_q ? pos_rdata[wve_pkg::TIME_W-1:0] : '0;
  assign old_x  = pos_rvld_q ? pos_rdata[wve_pkg::TIME_W +: 16] : '0;
  assign old_y  = pos_rvld_q ? pos_rdata[wve_pkg::TIME_W+16 +: 16] : '0;
  assign old_vx = hist_rvld_q ? hist_rdata[0 +: wve_pkg::VEL_W] : '0;
  assign old_vy = hist_rvld_q ? hist_rdata[wve_pkg::VEL_W +: wve_pkg::VEL_W] : '0;

  assign dpx = 17'(px_q) - 17'(old_x);
  assign dpy = 17'(py_q) - 17'(old_y);
  assign apx = dpx[16] ? 17'(-dpx) : 17'(dpx);
  assign apy = dpy[16] ? 17'(-dpy) : 17'(dpy);
  assign dt  = {1'b0, t_q} - {1'b0, old_t};

  assign absx  = sumx_q[SUM_W-1] ? SUM_W'(-sumx_q) : SUM_W'(sumx_q);
  assign absy  = sumy_q[SUM_W-1] ? SUM_W'(-sumy_q) : SUM_W'(sumy_q);
  assign ppx   = mabsx_q * rcp_q[RPW-1 -: CHK];
  assign ppy   = mabsy_q * rcp_q[RPW-1 -: CHK];
  assign mqx   = accx_q[RK +: wve_pkg::VEL_W];
  assign mqy   = accy_q[RK +: wve_pkg::VEL_W];
  assign prodx = mx_q * mx_q;
  assign prody = my_q * my_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= sample_i.pos_x;
      py_q <= sample_i.pos_y;
      t_q  <= sample_i.time_us;
    end
    if (state_q == wve_pkg::S_LOAD) begin
      magx_q  <= wve_pkg::MAG_W'(apx) * wve_pkg::MAG_W'(wve_pkg::USEC_PER_SEC);
      magy_q  <= wve_pkg::MAG_W'(apy) * wve_pkg::MAG_W'(wve_pkg::USEC_PER_SEC);
      negx_q  <= dpx[16];
      negy_q  <= dpy[16];
      dtpos_q <= !dt[wve_pkg::TIME_W] && (dt != '0);
      dt_q    <= dt[wve_pkg::TIME_W-1:0];
    end
    if (state_q == wve_pkg::S_VEL) begin
      vx_q <= dtpos_q ? sat_vel(qx, negx_q) : '0;
      vy_q <= dtpos_q ? sat_vel(qy, negy_q) : '0;
    end
    // The reciprocal is consumed one byte per cycle, most significant byte first.
    if (mdiv_go) begin
      mabsx_q <= absx;
      mabsy_q <= absy;
      accx_q  <= '0;
      accy_q  <= '0;
      rcp_q   <= RECIP;
    end else if (mcnt_q != '0) begin
      accx_q <= {accx_q[ACC_W-CHK-1:0], {CHK{1'b0}}} + ACC_W'(ppx);
      accy_q <= {accy_q[ACC_W-CHK-1:0], {CHK{1'b0}}} + ACC_W'(ppy);
      rcp_q  <= {rcp_q[RPW-CHK-1:0], {CHK{1'b0}}};
    end
    if (state_q == wve_pkg::S_MEAN) begin
      mx_q <= sumx_q[SUM_W-1] ? -wve_pkg::VEL_W'(mqx) : wve_pkg::VEL_W'(mqx);
      my_q <= sumy_q[SUM_W-1] ? -wve_pkg::VEL_W'(mqy) : wve_pkg::VEL_W'(mqy);
    end
    if (state_q == wve_pkg::S_SQ) begin
      sqx_q <= prodx;
      sqy_q <= prody;
    end
    if (state_q == wve_pkg::S_OUT && out_free) begin
      result_o.vel_x   <= mx_q;
      result_o.vel_y   <= my_q;
      result_o.speed   <= root;
      result_o.heading <= heading;
    end
  end

  wve_div #(.NW(wve_pkg::MAG_W), .DW(wve_pkg::TIME_W)) u_vdiv_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (vdiv_go),
    .dividend_i (magx_q), .divisor_i (dt_q),
    .busy_o (vdivx_busy), .quotient_o (qx)
  );

  wve_div #(.NW(wve_pkg::MAG_W), .DW(wve_pkg::TIME_W)) u_vdiv_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (vdiv_go),
    .dividend_i (magy_q), .divisor_i (dt_q),
    .busy_o (vdivy_busy), .quotient_o (qy)
  );

  wve_sqrt u_sqrt (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (fin_go),
    .radicand_i (sqx_q + sqy_q),
    .busy_o (sqrt_busy), .root_o (root)
  );

  wve_cordic u_cordic (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (fin_go),
    .x_i (mx_q), .y_i (my_q),
    .busy_o (cordic_busy), .heading_o (heading)
  );

  assign result_o.valid = out_valid_q;

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == wve_pkg::S_LOAD)
    else $error("accepted item did not start the ring read");

  a_wslot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wslot_q <= AW'(WINDOW_DEPTH - 1))
    else $error("ring write slot out of range");

  a_hslot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hslot_q <= HAW'(AVG_DEPTH - 1))
    else $error("history slot out of range");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wve_pkg::S_IDLE |-> !vdivx_busy && (mcnt_q == '0) && !sqrt_busy && !cordic_busy)
    else $error("arithmetic lane busy while idle");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wve_pkg::S_OUT && out_free |=> out_valid_q)
    else $error("finished item not presented");

endmodule

`default_nettype wire
